>>> hdl/ira_pkg.sv
// ----------------------------------------------------------------------------
// ira_pkg
// Shared types and fixed constants of the interval register allocator.
// ----------------------------------------------------------------------------
package ira_pkg;

  localparam int VREG_W    = 16;
  localparam int TIME_W    = 16;
  localparam int PREG_W    = 4;
  localparam int MASK_BITS = 16;

  // item opcodes
  localparam logic OP_ALLOC  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // registers 0, 2, 4, 5, 11 and 15 reserved after reset
  localparam logic [MASK_BITS-1:0] RESERVED_RESET = 16'h8835;

  typedef struct packed {
    logic              op;
    logic [VREG_W-1:0] vreg_id;
    logic [TIME_W-1:0] live_start;
    logic [TIME_W-1:0] live_end;
    logic              operand_is_number;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [PREG_W-1:0] reg_num;
    logic              table_full;
  } res_t;

endpackage

>>> hdl/ira_req_if.sv
// ----------------------------------------------------------------------------
// ira_req_if
// Request channel: one allocate or lookup item per handshake.
// ----------------------------------------------------------------------------
interface ira_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] vreg_id;
  logic [15:0] live_start;
  logic [15:0] live_end;
  logic        operand_is_number;

  modport source (
    output valid, op, vreg_id, live_start, live_end, operand_is_number,
    input  ready
  );
  modport sink (
    input  valid, op, vreg_id, live_start, live_end, operand_is_number,
    output ready
  );
endinterface

>>> hdl/ira_rsp_if.sv
// ----------------------------------------------------------------------------
// ira_rsp_if
// Response channel: one result item per request item.
// ----------------------------------------------------------------------------
interface ira_rsp_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [3:0] reg_num;
  logic       table_full;

  modport source (
    output valid, found, reg_num, table_full,
    input  ready
  );
  modport sink (
    input  valid, found, reg_num, table_full,
    output ready
  );
endinterface

>>> hdl/ira_cfg_if.sv
// ----------------------------------------------------------------------------
// ira_cfg_if
// Configuration write channel for the reserved register mask.
// ----------------------------------------------------------------------------
interface ira_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] reserved_mask;

  modport source (
    output valid, reserved_mask,
    input  ready
  );
  modport sink (
    input  valid, reserved_mask,
    output ready
  );
endinterface

>>> hdl/ira_busy_mem.sv
// ----------------------------------------------------------------------------
// ira_busy_mem
// Busy-until times per physical register, registered read, with valid flops
// so that a never-written register reads as free.
// ----------------------------------------------------------------------------
module ira_busy_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [AW-1:0]              raddr,
  output logic [ira_pkg::TIME_W-1:0] rdata,
  output logic                       rvalid,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [ira_pkg::TIME_W-1:0] wdata
);

  logic [ira_pkg::TIME_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata  <= mem[raddr];
    rvalid <= vld[raddr];
  end

  // invalid entry stands for busy-until minus one
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

endmodule

>>> hdl/ira_table_mem.sv
// ----------------------------------------------------------------------------
// ira_table_mem
// Interval table: vreg id, has-register flag and register, registered read.
// ----------------------------------------------------------------------------
module ira_table_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 21
) (
  input  logic          clk,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ira_ctrl.sv
// ----------------------------------------------------------------------------
// ira_ctrl
// Sequencer: scans the busy memory for an allocate, the interval table for
// a lookup, and writes back the chosen register and the new table entry.
// ----------------------------------------------------------------------------
module ira_ctrl #(
  parameter int NUM_PHYS_REGS = 16,
  parameter int MAX_INTERVALS = 256,
  parameter int RW  = $clog2(NUM_PHYS_REGS),
  parameter int AW  = $clog2(MAX_INTERVALS),
  parameter int TDW = ira_pkg::VREG_W + 1 + RW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ira_pkg::MASK_BITS-1:0] mask,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  ira_pkg::req_t                 req,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ira_pkg::res_t                 res,
  output logic [RW-1:0]                 busy_raddr,
  input  logic [ira_pkg::TIME_W-1:0]    busy_rdata,
  input  logic                          busy_rvalid,
  output logic                          busy_we,
  output logic [RW-1:0]                 busy_waddr,
  output logic [ira_pkg::TIME_W-1:0]    busy_wdata,
  output logic [AW-1:0]                 tbl_raddr,
  input  logic [TDW-1:0]                tbl_rdata,
  output logic                          tbl_we,
  output logic [AW-1:0]                 tbl_waddr,
  output logic [TDW-1:0]                tbl_wdata
);

  localparam int RCW = $clog2(NUM_PHYS_REGS + 1);
  localparam int CW  = $clog2(MAX_INTERVALS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]     state;
  ira_pkg::req_t  item;
  logic [CW-1:0]  count;
  logic [RCW-1:0] rd_r;
  logic [RW-1:0]  chk_r;
  logic [CW-1:0]  rd_i;
  logic           pend;

  logic issue_r, reserved, hit_r, alloc_end;
  logic issue_i, tbl_match, tbl_has, look_end;
  logic [RW-1:0] tbl_reg;

  // allocate scan: read register rd_r, check chk_r in the next cycle
  assign issue_r   = rd_r < RCW'(NUM_PHYS_REGS);
  assign reserved  = (32'(chk_r) < 32'(ira_pkg::MASK_BITS)) ? mask[4'(chk_r)] : 1'b0;
  assign hit_r     = pend && !reserved && (!busy_rvalid || busy_rdata < item.live_start);
  assign alloc_end = hit_r || (!pend && !issue_r);

  // lookup scan over entries below count
  assign issue_i   = rd_i < count;
  assign tbl_has   = tbl_rdata[RW];
  assign tbl_reg   = tbl_rdata[RW-1:0];
  assign tbl_match = pend && (tbl_rdata[TDW-1 -: ira_pkg::VREG_W] == item.vreg_id);
  assign look_end  = tbl_match || (!pend && !issue_i);

  assign busy_raddr = rd_r[RW-1:0];
  assign busy_we    = (state == S_ALLOC) && hit_r;
  assign busy_waddr = chk_r;
  assign busy_wdata = item.live_end;

  assign tbl_raddr = rd_i[AW-1:0];
  assign tbl_we    = (state == S_ALLOC) && alloc_end;
  assign tbl_waddr = count[AW-1:0];
  assign tbl_wdata = {item.vreg_id, hit_r, chk_r};

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            item <= req;
            pend <= 1'b0;
            rd_r <= '0;
            rd_i <= '0;
            if (req.op == ira_pkg::OP_ALLOC) begin
              if (count == CW'(MAX_INTERVALS)) begin
                res   <= '{found: 1'b0, reg_num: '0, table_full: 1'b1};
                state <= S_EMIT;
              end else begin
                state <= S_ALLOC;
              end
            end else if (req.operand_is_number) begin
              res   <= '0;
              state <= S_EMIT;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_ALLOC: begin
          if (alloc_end) begin
            count <= count + 1'b1;
            res   <= '{found: hit_r, reg_num: hit_r ? 4'(chk_r) : 4'd0, table_full: 1'b0};
            state <= S_EMIT;
          end else begin
            pend <= issue_r;
            if (issue_r) begin
              rd_r  <= rd_r + 1'b1;
              chk_r <= rd_r[RW-1:0];
            end
          end
        end
        S_LOOK: begin
          if (look_end) begin
            res <= '{found: tbl_match && tbl_has,
                     reg_num: (tbl_match && tbl_has) ? 4'(tbl_reg) : 4'd0,
                     table_full: 1'b0};
            state <= S_EMIT;
          end else begin
            pend <= issue_i;
            if (issue_i) begin
              rd_i <= rd_i + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // every table append bumps the fill count by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    tbl_we |=> (count == $past(count) + 1'b1))
    else $error("fill count did not follow table write");

  // a busy time is only written along with an entry that has a register
  a_busy_with_entry: assert property (@(posedge clk) disable iff (rst)
    busy_we |-> (tbl_we && tbl_wdata[RW]))
    else $error("busy write without table entry");

  // an accepted item always starts work
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != S_IDLE))
    else $error("accepted item dropped");

  // a dropped allocate never reports a register
  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.found && res.table_full))
    else $error("full table result reports a register");

  // fill count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> (count < CW'(MAX_INTERVALS)))
    else $error("table write past depth");

endmodule

>>> hdl/interval_register_allocator.sv
// ----------------------------------------------------------------------------
// interval_register_allocator
// Greedy linear-scan register allocation with an interval table lookup.
// ----------------------------------------------------------------------------
// Each request item is either an allocate or a lookup, and each gives exactly
// one response item. Items are handled one at a time. An allocate scans the
// busy-until memory one physical register per cycle, lowest number first, and
// stops at the first register that is not reserved and whose busy time is
// below the interval's start, or after the last register when none is free.
// A lookup scans the interval table one entry per cycle through the single
// read port of the table memory, and stops at the first matching entry or
// after the last entry. A constant operand or a full table answers without
// a scan. A response register sits on the output, so the next item is
// accepted while a result still waits to be taken; the sequencer waits while
// that register stays full. The reserved mask is written through the cfg
// channel, which is always ready; write it only while the block is idle. No
// clearing pass after reset: busy times carry valid flops and the interval
// table is guarded by its fill count.
// ----------------------------------------------------------------------------
module interval_register_allocator #(
  parameter int NUM_PHYS_REGS = 16,
  parameter int MAX_INTERVALS = 256
) (
  input logic       clk,
  input logic       rst,
  ira_req_if.sink   req,
  ira_rsp_if.source rsp,
  ira_cfg_if.sink   cfg
);

  localparam int RW  = $clog2(NUM_PHYS_REGS);
  localparam int AW  = $clog2(MAX_INTERVALS);
  localparam int TDW = ira_pkg::VREG_W + 1 + RW;

  // reserved register mask
  logic [ira_pkg::MASK_BITS-1:0] mask;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= ira_pkg::RESERVED_RESET;
    end else if (cfg.valid) begin
      mask <= cfg.reserved_mask;
    end
  end

  // request item packed for the sequencer
  ira_pkg::req_t req_item;

  assign req_item = '{op: req.op, vreg_id: req.vreg_id, live_start: req.live_start,
                      live_end: req.live_end, operand_is_number: req.operand_is_number};

  logic          res_valid;
  logic          res_ready;
  ira_pkg::res_t res;

  logic [RW-1:0]              busy_raddr;
  logic [ira_pkg::TIME_W-1:0] busy_rdata;
  logic                       busy_rvalid;
  logic                       busy_we;
  logic [RW-1:0]              busy_waddr;
  logic [ira_pkg::TIME_W-1:0] busy_wdata;

  logic [AW-1:0]  tbl_raddr;
  logic [TDW-1:0] tbl_rdata;
  logic           tbl_we;
  logic [AW-1:0]  tbl_waddr;
  logic [TDW-1:0] tbl_wdata;

  ira_ctrl #(
    .NUM_PHYS_REGS (NUM_PHYS_REGS),
    .MAX_INTERVALS (MAX_INTERVALS),
    .RW            (RW),
    .AW            (AW),
    .TDW           (TDW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .mask        (mask),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req         (req_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .busy_raddr  (busy_raddr),
    .busy_rdata  (busy_rdata),
    .busy_rvalid (busy_rvalid),
    .busy_we     (busy_we),
    .busy_waddr  (busy_waddr),
    .busy_wdata  (busy_wdata),
    .tbl_raddr   (tbl_raddr),
    .tbl_rdata   (tbl_rdata),
    .tbl_we      (tbl_we),
    .tbl_waddr   (tbl_waddr),
    .tbl_wdata   (tbl_wdata)
  );

  // busy-until time per physical register
  ira_busy_mem #(
    .DEPTH (NUM_PHYS_REGS),
    .AW    (RW)
  ) u_busy (
    .clk    (clk),
    .rst    (rst),
    .raddr  (busy_raddr),
    .rdata  (busy_rdata),
    .rvalid (busy_rvalid),
    .we     (busy_we),
    .waddr  (busy_waddr),
    .wdata  (busy_wdata)
  );

  // interval table, appended in order
  ira_table_mem #(
    .DEPTH (MAX_INTERVALS),
    .AW    (AW),
    .DW    (TDW)
  ) u_table (
    .clk   (clk),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata)
  );

  // response register: frees the sequencer while the sink stalls
  logic          out_valid;
  ira_pkg::res_t out_item;

  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.found      = out_item.found;
  assign rsp.reg_num    = out_item.reg_num;
  assign rsp.table_full = out_item.table_full;

endmodule

>>> dv/ira_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ira_result_checker
// Watches the request, response and mask channels, keeps its own copy of the
// allocator state, and checks every response item against its prediction.
// ----------------------------------------------------------------------------
module ira_result_checker #(
  parameter int NUM_REGS   = 16,
  parameter int TABLE_SIZE = 256
) (
  input  logic clk,
  input  logic rst,
  ira_req_if   req,
  ira_rsp_if   rsp,
  ira_cfg_if   cfg,
  output int   errors,
  output int   outstanding
);

  logic [ira_pkg::MASK_BITS-1:0] mask_q;
  logic signed [16:0]            busy_q [NUM_REGS];
  logic [ira_pkg::VREG_W-1:0]    tab_vreg [TABLE_SIZE];
  int unsigned                   tab_reg [TABLE_SIZE];
  logic                          tab_has [TABLE_SIZE];
  int unsigned                   tab_cnt;
  ira_pkg::res_t                 due_q [$];

  // Greedy pick on allocate, first-match search on lookup.
  function automatic ira_pkg::res_t allocate_or_find(input ira_pkg::req_t it);
    ira_pkg::res_t r;
    int unsigned   k;
    logic          got;
    r   = '0;
    got = 1'b0;
    if (it.op == ira_pkg::OP_ALLOC) begin
      if (tab_cnt >= TABLE_SIZE) begin
        r.table_full = 1'b1;
      end else begin
        for (k = 0; k < NUM_REGS && !got; k++) begin
          if (!(k < ira_pkg::MASK_BITS && mask_q[k]) &&
              busy_q[k] < $signed({1'b0, it.live_start})) begin
            got       = 1'b1;
            busy_q[k] = $signed({1'b0, it.live_end});
            r.found   = 1'b1;
            r.reg_num = k[ira_pkg::PREG_W-1:0];
            tab_reg[tab_cnt] = k;
          end
        end
        tab_vreg[tab_cnt] = it.vreg_id;
        tab_has[tab_cnt]  = got;
        tab_cnt++;
      end
    end else if (!it.operand_is_number) begin
      for (k = 0; k < tab_cnt && !got; k++) begin
        if (tab_vreg[k] == it.vreg_id) begin
          got = 1'b1;
          if (tab_has[k]) begin
            r.found   = 1'b1;
            r.reg_num = tab_reg[k][ira_pkg::PREG_W-1:0];
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    ira_pkg::req_t it;
    ira_pkg::res_t got_r;
    ira_pkg::res_t want;
    if (rst) begin
      mask_q  = ira_pkg::RESERVED_RESET;
      tab_cnt = 0;
      for (int i = 0; i < NUM_REGS; i++) busy_q[i] = '1;
      due_q.delete();
      errors  = 0;
    end else begin
      if (cfg.valid && cfg.ready) mask_q = cfg.reserved_mask;

      if (rsp.valid && rsp.ready) begin
        got_r.found      = rsp.found;
        got_r.reg_num    = rsp.reg_num;
        got_r.table_full = rsp.table_full;
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result found=%0d reg=%0d full=%0d",
                   $time, got_r.found, got_r.reg_num, got_r.table_full);
          errors++;
        end else begin
          want = due_q.pop_front();
          if (got_r.found !== want.found) begin
            $display("%0t: found expected %0d got %0d", $time, want.found, got_r.found);
            errors++;
          end
          if (got_r.reg_num !== want.reg_num) begin
            $display("%0t: reg_num expected %0d got %0d",
                     $time, want.reg_num, got_r.reg_num);
            errors++;
          end
          if (got_r.table_full !== want.table_full) begin
            $display("%0t: table_full expected %0d got %0d",
                     $time, want.table_full, got_r.table_full);
            errors++;
          end
        end
      end

      if (req.valid && req.ready) begin
        it.op                = req.op;
        it.vreg_id           = req.vreg_id;
        it.live_start        = req.live_start;
        it.live_end          = req.live_end;
        it.operand_is_number = req.operand_is_number;
        due_q.push_back(allocate_or_find(it));
      end
    end
    outstanding = due_q.size();
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the interval register allocator: a directed
// opening, then random phases under several reserved masks with random
// stalls on both channels. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_REGS    = 16;
  localparam int TABLE_SIZE  = 256;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 141;
  // longest item is a full table scan plus its overhead
  localparam int SETTLE_CYCLES = TABLE_SIZE + 50;

  logic clk;
  logic rst;
  int   errors;
  int   outstanding;

  ira_req_if req_ch ();
  ira_rsp_if rsp_ch ();
  ira_cfg_if cfg_ch ();

  interval_register_allocator #(
    .NUM_PHYS_REGS (NUM_REGS),
    .MAX_INTERVALS (TABLE_SIZE)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  ira_result_checker #(
    .NUM_REGS   (NUM_REGS),
    .TABLE_SIZE (TABLE_SIZE)
  ) u_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg         (cfg_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // stimulus bookkeeping
  int               cursor;      // rolling instruction index for intervals
  logic [15:0]      vreg_pool [$];
  bit               req_quiet;   // sender runs back to back while set
  bit               rsp_quiet;   // receiver starts no new stall while set
  int               stall_left;

  // mostly no gap, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // response side: random backpressure, with quiet stretches
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if ($urandom_range(0, 199) == 0) rsp_quiet = !rsp_quiet;
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!rsp_quiet) stall_left = idle_len();
      end
    end
  end

  function automatic ira_pkg::req_t alloc_item(input logic [15:0] v,
                                               input logic [15:0] s,
                                               input logic [15:0] e);
    ira_pkg::req_t it;
    it            = '0;
    it.op         = ira_pkg::OP_ALLOC;
    it.vreg_id    = v;
    it.live_start = s;
    it.live_end   = e;
    return it;
  endfunction

  function automatic ira_pkg::req_t lookup_item(input logic [15:0] v, input logic num);
    ira_pkg::req_t it;
    it                   = '0;
    it.op                = ira_pkg::OP_LOOKUP;
    it.vreg_id           = v;
    it.operand_is_number = num;
    return it;
  endfunction

  // Random item. Allocates mostly follow a rising instruction index so that
  // intervals overlap and contend for registers; a tenth use any times at all
  // (end before start, times at the top of the range). Lookups mostly name a
  // vreg that was allocated, so the table search actually hits.
  function automatic ira_pkg::req_t rand_item();
    ira_pkg::req_t it;
    int            s;
    int            e;
    it.live_start        = 16'($urandom);
    it.live_end          = 16'($urandom);
    it.operand_is_number = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 35) begin
      it.op = ira_pkg::OP_ALLOC;
      if (vreg_pool.size() > 0 && $urandom_range(0, 3) == 0)
        it.vreg_id = vreg_pool[$urandom_range(0, vreg_pool.size() - 1)];
      else
        it.vreg_id = 16'($urandom);
      if ($urandom_range(0, 9) != 0) begin
        cursor = (cursor + $urandom_range(0, 100)) % 60000;
        s      = cursor + $urandom_range(0, 20);
        e      = s + $urandom_range(0, 400);
        if (e > 65535) e = 65535;
        it.live_start = s[15:0];
        it.live_end   = e[15:0];
      end
      if (vreg_pool.size() < 400) vreg_pool.push_back(it.vreg_id);
    end else begin
      it.op                = ira_pkg::OP_LOOKUP;
      it.operand_is_number = ($urandom_range(0, 9) == 0);
      if (vreg_pool.size() > 0 && $urandom_range(0, 3) != 0)
        it.vreg_id = vreg_pool[$urandom_range(0, vreg_pool.size() - 1)];
      else
        it.vreg_id = 16'($urandom);
    end
    return it;
  endfunction

  // one request item; valid stays up across back-to-back items
  task automatic push_item(input ira_pkg::req_t it);
    int gap;
    gap = req_quiet ? 0 : idle_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid             <= 1'b1;
    req_ch.op                <= it.op;
    req_ch.vreg_id           <= it.vreg_id;
    req_ch.live_start        <= it.live_start;
    req_ch.live_end          <= it.live_end;
    req_ch.operand_is_number <= it.operand_is_number;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // stop sending and wait for every outstanding result; checker state is
  // read at the falling edge so it is settled
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_mask(input logic [15:0] m);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.reserved_mask <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] m;
    rst                      = 1'b1;
    req_ch.valid             = 1'b0;
    req_ch.op                = ira_pkg::OP_ALLOC;
    req_ch.vreg_id           = '0;
    req_ch.live_start        = '0;
    req_ch.live_end          = '0;
    req_ch.operand_is_number = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.reserved_mask     = '0;
    cursor                   = 0;
    req_quiet                = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed opening, reset mask: free registers 1 3 6 7 8 9 10 12 13 14.
    push_item(lookup_item(16'h0000, 1'b0));             // empty table, unknown
    push_item(alloc_item(16'h0000, 16'd0, 16'd0));      // reg 1, busy until 0
    push_item(alloc_item(16'hFFFF, 16'd0, 16'hFFFF));   // equal time skips 1 -> 3
    push_item(alloc_item(16'h1234, 16'd1, 16'd5));      // reg 1 again
    push_item(alloc_item(16'h1234, 16'd5, 16'd10));     // duplicate vreg, reg 6
    push_item(lookup_item(16'h1234, 1'b0));             // first entry wins: 1
    push_item(lookup_item(16'hFFFF, 1'b1));             // constant operand
    push_item(lookup_item(16'hFFFF, 1'b0));             // reg 3
    push_item(lookup_item(16'h0000, 1'b0));             // reg 1
    push_item(lookup_item(16'hBEEF, 1'b0));             // unknown vreg
    // use up every register still free at time 0
    for (int i = 0; i < 7; i++)
      push_item(alloc_item(16'(16'h0100 + i), 16'd0, 16'd0));
    push_item(alloc_item(16'hA5A5, 16'd0, 16'd0));      // nothing free
    push_item(lookup_item(16'hA5A5, 1'b0));             // entry without register
    push_item(alloc_item(16'h5A5A, 16'hFFFF, 16'd0));   // top start, end below it
    push_item(lookup_item(16'h5A5A, 1'b0));
    drain();

    // Random phases; the mask changes only while the block is idle.
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) m = 16'h0000;
      else if (p == 1) m = 16'hFFFF;
      else if (p == PHASES - 1) m = ira_pkg::RESERVED_RESET;
      else m = 16'($urandom_range(0, 65535));
      write_mask(m);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 49) == 0) req_quiet = !req_quiet;
        push_item(rand_item());
      end
      drain();
    end

    // catch any stray result after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

>>> interval_register_allocator.f
hdl/ira_pkg.sv
hdl/ira_req_if.sv
hdl/ira_rsp_if.sv
hdl/ira_cfg_if.sv
hdl/ira_busy_mem.sv
hdl/ira_table_mem.sv
hdl/ira_ctrl.sv
hdl/interval_register_allocator.sv
dv/ira_result_checker.sv
dv/tb_top.sv
